// ===== src/icw_pkg.sv =====
// Package for the wraparound image convolution block.
// Holds widths, register indexes, controller states and command records.
// No dependencies.
`default_nettype none
package icw_pkg;
  localparam int XW = 8;
  localparam int YW = 8;
  localparam int AW = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int PIXW = 32;
  localparam int CFGW = 60;
  localparam int CFGIW = 3;
  localparam int TAPW = 12;
  localparam int SUMW = 26;

  localparam logic [CFGIW-1:0] REG_IMG_W = 3'd0;
  localparam logic [CFGIW-1:0] REG_IMG_H = 3'd1;
  localparam logic [CFGIW-1:0] REG_KER_W = 3'd2;
  localparam logic [CFGIW-1:0] REG_KER_H = 3'd3;
  localparam logic [CFGIW-1:0] REG_TAPS_A = 3'd4;
  localparam logic [CFGIW-1:0] REG_TAPS_B = 3'd5;
  localparam logic [CFGIW-1:0] REG_GAIN = 3'd6;
  localparam logic [CFGIW-1:0] REG_OFFSET = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MOD, ST_READ, ST_ACC, ST_LAST, ST_SCALE, ST_ROUND, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic mod_step;
    logic init;
    logic step;
    logic acc;
    logic scale;
    logic round;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last_tap;
    logic no_taps;
    logic mod_done;
  } stat_t;
endpackage
`default_nettype wire

// ===== src/icw_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface icw_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/icw_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module icw_ram #(parameter int WIDTH = 32, parameter int DEPTH = 256) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== src/icw_ctrl.sv =====
// Controller state machine of the convolution block.
// Depends on icw_pkg.
`default_nettype none
module icw_ctrl import icw_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  rd_req,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output      cmd_t  cmd,
  output      logic  busy,
  output      logic  out_valid
);
  state_t state_r, state_nxt;
  logic ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (rd_req) state_nxt = ST_MOD;
      ST_MOD: if (stat.mod_done) state_nxt = stat.no_taps ? ST_SCALE : ST_READ;
      ST_READ: state_nxt = stat.last_tap ? ST_LAST : ST_ACC;
      ST_ACC: state_nxt = stat.last_tap ? ST_LAST : ST_ACC;
      ST_LAST: state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_OUT;
      ST_OUT: if (!ovalid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.start = rd_req;
      end
      ST_MOD: begin
        cmd.mod_step = !stat.mod_done;
        cmd.init = stat.mod_done;
      end
      ST_READ: cmd.step = 1'b1;
      ST_ACC: begin
        cmd.acc = 1'b1;
        cmd.step = 1'b1;
      end
      ST_LAST: cmd.acc = 1'b1;
      ST_SCALE: cmd.scale = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_OUT: cmd.load_out = !ovalid_r || out_ready;
      default: busy = 1'b1;
    endcase
    ovalid_nxt = cmd.load_out || (ovalid_r && !out_ready);
  end

  assign out_valid = ovalid_r;
endmodule
`default_nettype wire

// ===== src/icw_dp.sv =====
// Datapath: configuration registers, frame store, tap walker, accumulators
// and output scaling. Depends on icw_pkg and icw_ram.
`default_nettype none
module icw_dp import icw_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFGIW-1:0] cfg_idx,
  input  wire logic [CFGW-1:0]  cfg_data,
  input  wire logic             wr_en,
  input  wire logic [XW-1:0]    in_x,
  input  wire logic [YW-1:0]    in_y,
  input  wire logic [PIXW-1:0]  in_pix,
  input  wire cmd_t             cmd,
  output      stat_t            stat,
  output      logic [XW-1:0]    res_x,
  output      logic [YW-1:0]    res_y,
  output      logic [PIXW-1:0]  res_pix
);
  logic [8:0] img_w_r, img_h_r, wlim, hlim;
  logic [1:0] ker_w_r, ker_h_r, kw, kh;
  logic [59:0] taps_a_r;
  logic [47:0] taps_b_r;
  logic signed [15:0] gain_r;
  logic signed [8:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= 9'd256;
      img_h_r <= 9'd256;
      ker_w_r <= 2'd1;
      ker_h_r <= 2'd1;
      taps_a_r <= 60'd64;
      taps_b_r <= '0;
      gain_r <= 16'sd256;
      offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IMG_W: img_w_r <= cfg_data[8:0];
        REG_IMG_H: img_h_r <= cfg_data[8:0];
        REG_KER_W: ker_w_r <= cfg_data[1:0];
        REG_KER_H: ker_h_r <= cfg_data[1:0];
        REG_TAPS_A: taps_a_r <= cfg_data;
        REG_TAPS_B: taps_b_r <= cfg_data[47:0];
        REG_GAIN: gain_r <= cfg_data[15:0];
        REG_OFFSET: offset_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign wlim = (img_w_r == 9'd0) ? 9'd1 : (img_w_r > 9'd256 ? 9'd256 : img_w_r);
  assign hlim = (img_h_r == 9'd0) ? 9'd1 : (img_h_r > 9'd256 ? 9'd256 : img_h_r);
  assign kw = ker_w_r;
  assign kh = ker_h_r;

  // Tap walker: row/column counters and wrapped neighbor coordinates.
  logic [1:0] fx_r, fy_r, fxa_r, fya_r;
  logic [XW-1:0] x_r, nx_r, nx0_r, sx_r;
  logic [YW-1:0] y_r, ny_r, sy_r;
  logic [8:0] wx, wy;
  logic [8:0] xm, ym;
  logic [3:0] mcnt_r;

  // One compare and subtract; the value must be below twice the modulus.
  function automatic logic [8:0] wrap_sub(input logic [9:0] v, input logic [8:0] m);
    logic [9:0] t;
    t = v;
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[8:0];
  endfunction

  // Start coordinates are reduced modulo the frame size by a restoring
  // remainder, one position bit per cycle, over all eight bits of each coordinate.
  logic [8:0] rx_r, ry_r;

  always_comb begin
    wx = wrap_sub({1'b0, rx_r} + {1'b0, wlim} - 10'(kw >> 1), wlim);
    wy = wrap_sub({1'b0, ry_r} + {1'b0, hlim} - 10'(kh >> 1), hlim);
    xm = wx;
    ym = wy;
  end

  logic last_col, last_row;
  assign last_col = (fx_r == kw - 2'd1);
  assign last_row = (fy_r == kh - 2'd1);

  always_comb begin
    stat = '0;
    stat.last_tap = last_col && last_row;
    stat.no_taps = (kw == 2'd0) || (kh == 2'd0);
    stat.mod_done = (mcnt_r == 4'd0);
  end

  logic [8:0] nx_inc, ny_inc;
  assign nx_inc = wrap_sub({2'b0, nx_r} + 10'd1, wlim);
  assign ny_inc = wrap_sub({2'b0, ny_r} + 10'd1, hlim);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r <= in_x;
      y_r <= in_y;
      sx_r <= in_x;
      sy_r <= in_y;
      rx_r <= '0;
      ry_r <= '0;
      mcnt_r <= 4'd8;
    end else if (cmd.mod_step) begin
      rx_r <= wrap_sub({rx_r, sx_r[XW-1]}, wlim);
      ry_r <= wrap_sub({ry_r, sy_r[YW-1]}, hlim);
      sx_r <= {sx_r[XW-2:0], 1'b0};
      sy_r <= {sy_r[YW-2:0], 1'b0};
      mcnt_r <= mcnt_r - 4'd1;
    end else if (cmd.init) begin
      nx_r <= xm[7:0];
      nx0_r <= xm[7:0];
      ny_r <= ym[7:0];
      fx_r <= '0;
      fy_r <= '0;
    end else if (cmd.step) begin
      if (last_col) begin
        fx_r <= '0;
        fy_r <= fy_r + 2'd1;
        nx_r <= nx0_r;
        ny_r <= ny_inc[7:0];
      end else begin
        fx_r <= fx_r + 2'd1;
        nx_r <= nx_inc[7:0];
      end
    end
    if (cmd.start || cmd.step) begin
      fxa_r <= fx_r;
      fya_r <= fy_r;
    end
  end

  logic we;
  logic [AW-1:0] addr;
  logic [PIXW-1:0] rdata;
  assign we = wr_en;
  assign addr = wr_en ? {in_y, in_x} : {ny_r, nx_r};
  icw_ram #(.WIDTH(PIXW), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .addr(addr), .wdata(in_pix), .rdata(rdata)
  );

  logic [3:0] tk;
  logic [TAPW-1:0] tap_raw;
  assign tk = 4'(fya_r) * 4'd3 + 4'(fxa_r);
  always_comb begin
    case (tk)
      4'd0: tap_raw = taps_a_r[11:0];
      4'd1: tap_raw = taps_a_r[23:12];
      4'd2: tap_raw = taps_a_r[35:24];
      4'd3: tap_raw = taps_a_r[47:36];
      4'd4: tap_raw = taps_a_r[59:48];
      4'd5: tap_raw = taps_b_r[11:0];
      4'd6: tap_raw = taps_b_r[23:12];
      4'd7: tap_raw = taps_b_r[35:24];
      4'd8: tap_raw = taps_b_r[47:36];
      default: tap_raw = '0;
    endcase
  end

  logic signed [SUMW-1:0] sum_r [4];
  logic signed [SUMW+16:0] prod_r [4];
  logic [7:0] res_r [4];
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      if (cmd.start) sum_r[c] <= '0;
      else if (cmd.acc)
        sum_r[c] <= sum_r[c] + SUMW'($signed({1'b0, rdata[8*c +: 8]}) * $signed(tap_raw));
      if (cmd.scale)
        prod_r[c] <= (SUMW+17)'(sum_r[c] * gain_r) + (SUMW+17)'($signed({offset_r, 14'd0}));
      if (cmd.round) begin
        if (prod_r[c] < 0) res_r[c] <= 8'd0;
        else if (prod_r[c] >= (SUMW+17)'(256 * 16384)) res_r[c] <= 8'd255;
        else res_r[c] <= prod_r[c][21:14];
      end
    end
  end

  // Output register: holds a finished result until its transfer so that
  // the next items can be taken meanwhile.
  logic [XW-1:0] ox_r;
  logic [YW-1:0] oy_r;
  logic [PIXW-1:0] opix_r;
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ox_r <= x_r;
      oy_r <= y_r;
      opix_r <= {res_r[3], res_r[2], res_r[1], res_r[0]};
    end
  end

  assign res_x = ox_r;
  assign res_y = oy_r;
  assign res_pix = opix_r;
endmodule
`default_nettype wire

// ===== src/image_convolution_wrap_core.sv =====
// Top level of the wraparound image convolution block.
// Depends on icw_pkg, icw_if, icw_ctrl, icw_dp and icw_ram.
// A write item is written into the frame store when it is taken. A read item
// keeps the input closed after its transfer until its result is done: the
// remainder steps reduce the position modulo the frame size and the tap walker
// is loaded, the kernel taps are read one per cycle from the frame store and
// accumulated, the scale and round states scale and clamp, and the result
// moves into the output register. The next item can be taken once the result
// has moved there, which is also when it is offered. A read with an empty
// kernel skips the tap states. If the output register still holds an earlier
// result, the move waits until that transfer, which may happen in the same
// cycle.
`default_nettype none
module image_convolution_wrap_core import icw_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFGIW-1:0] cfg_idx,
  input  wire logic [CFGW-1:0]  cfg_data,
  icw_if.sink                   in_ch,
  icw_if.source                 out_ch
);
  // Input payload: {in_chan_3, in_chan_2, in_chan_1, in_chan_0, pos_y, pos_x, cmd}.
  logic in_cmd;
  logic [XW-1:0] in_x;
  logic [YW-1:0] in_y;
  logic [PIXW-1:0] in_pix;
  assign in_cmd = in_ch.data[0];
  assign in_x = in_ch.data[8:1];
  assign in_y = in_ch.data[16:9];
  assign in_pix = in_ch.data[48:17];

  cmd_t cmd;
  stat_t stat;
  logic busy, xfer;
  assign in_ch.ready = !busy;
  assign xfer = in_ch.valid && !busy;

  icw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .rd_req(xfer && in_cmd), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd), .busy(busy), .out_valid(out_ch.valid)
  );

  // The tap reads start only after the position is reduced; the controller
  // waits in its reduction state until the datapath reports it done.
  logic [XW-1:0] rx;
  logic [YW-1:0] ry;
  logic [PIXW-1:0] rpix;
  icw_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .wr_en(xfer && !in_cmd), .in_x(in_x), .in_y(in_y),
    .in_pix(in_pix), .cmd(cmd), .stat(stat), .res_x(rx), .res_y(ry),
    .res_pix(rpix)
  );

  // Output payload: {out_chan_3..out_chan_0, out_y, out_x}.
  assign out_ch.data = {rpix, ry, rx};
endmodule
`default_nettype wire
